FILE: sv/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg: shared types and constants of the first-fit block allocator
// Command and status codes, register indexes, channel payloads and the layout
// of one block table entry.
// ----------------------------------------------------------------------------
package ffba_pkg;

	// commands
	localparam logic [1:0] CMD_ALLOC   = 2'd0;
	localparam logic [1:0] CMD_FREE    = 2'd1;
	localparam logic [1:0] CMD_REALLOC = 2'd2;
	localparam logic [1:0] CMD_UNUSED  = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BADSIZE = 2'd1;
	localparam logic [1:0] ST_NOMEM   = 2'd2;
	localparam logic [1:0] ST_IGNORED = 2'd3;

	// configuration register indexes
	localparam logic REG_HEAP_LIMIT   = 1'b0;
	localparam logic REG_HEADER_BYTES = 1'b1;

	localparam logic [31:0] HeapLimitReset   = 32'hFFFF_FFFF;
	localparam logic [7:0]  HeaderBytesReset = 8'd32;
	localparam logic [26:0] MaxRequest       = 27'd100000000;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [26:0] request_size;
		logic [31:0] block_address;
	} req_t;

	typedef struct packed {
		logic [31:0] result_address;
		logic [1:0]  status;
		logic        kept_in_place;
		logic [6:0]  spare_blocks;
		logic [32:0] spare_bytes;
		logic [6:0]  used_blocks;
		logic [32:0] used_bytes;
	} rsp_t;

	// one block table entry
	typedef struct packed {
		logic        free;
		logic [26:0] size;
		logic [31:0] start;
	} entry_t;

endpackage

FILE: sv/ffba_ifs.sv
// ----------------------------------------------------------------------------
// ffba_ifs: channel interfaces of the first-fit block allocator
// Request, response and configuration write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ffba_req_if;
	logic             valid;
	logic             ready;
	ffba_pkg::req_t   payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface ffba_rsp_if;
	logic             valid;
	logic             ready;
	ffba_pkg::rsp_t   payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface ffba_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [31:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

FILE: sv/first_fit_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator_unit: first-fit heap block allocator
// Keeps a table of heap blocks and serves allocate, free and reallocate.
// ----------------------------------------------------------------------------
// Usage:
//   req takes one command beat (allocate, free, reallocate); rsp gives one result
//   beat per command with the address, status and heap totals after it. cfg
//   writes heap_limit (index 0) or header_bytes (index 1); write it only when idle.
// Timing:
//   Commands run one at a time; req.ready is high only in idle. A single
//   compare unit walks the table RAM (registered read) one entry a cycle.
//   A free or reallocate lookup scans the filled entries for the address; an
//   allocate scans for the first free block that fits and otherwise appends a
//   new block at the heap top. A moving reallocate runs both scans and then
//   releases the old block. Bad sizes skip the scan and go straight to the result.
// Reset and stall:
//   Reset empties the table, clears totals and loads the register defaults. A
//   result waits in an output register until rsp.ready; the next command is
//   accepted meanwhile and its result holds until the register frees.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_unit #(
	parameter int MAX_BLOCKS = 64,
	parameter int ADDR_BITS  = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	ffba_req_if.sink      req,
	ffba_rsp_if.source    rsp,
	ffba_cfg_if.sink      cfg
);

	localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam logic [32:0] PayMask = (ADDR_BITS >= 33) ? {33{1'b1}} :
		33'((65'd1 << ADDR_BITS) - 65'd1);
	localparam logic [31:0] LimMask = (ADDR_BITS >= 32) ? {32{1'b1}} :
		32'((64'd1 << ADDR_BITS) - 64'd1);

	typedef enum logic [5:0] {
		S_IDLE     = 6'b000001,
		S_FIND     = 6'b000010,
		S_FIT      = 6'b000100,
		S_APPEND   = 6'b001000,
		S_FREE_OLD = 6'b010000,
		S_RESP     = 6'b100000
	} state_t;

	state_t           state_q;
	logic [31:0]      heap_limit_q;
	logic [7:0]       header_q;
	logic [CW-1:0]    ent_cnt_q;
	logic [CW-1:0]    free_cnt_q;
	logic [32:0]      free_tot_q;
	logic [32:0]      used_tot_q;
	logic [31:0]      heap_top_q;

	logic [1:0]       cmd_q;
	logic [26:0]      size_q;
	logic [31:0]      addr_q;
	logic [31:0]      res_q;
	logic [1:0]       status_q;
	logic             kept_q;
	logic             rel_q;
	logic [IW-1:0]    old_idx_q;
	logic [26:0]      old_size_q;
	logic [31:0]      old_start_q;

	logic [CW-1:0]    ptr_q;
	logic             rvalid_s1;
	logic [IW-1:0]    idx_s1;

	logic             rsp_valid_q;
	ffba_pkg::rsp_t   rsp_q;

	logic                ram_we;
	logic [IW-1:0]       ram_waddr;
	ffba_pkg::entry_t    ram_wdata;
	logic [$bits(ffba_pkg::entry_t)-1:0] ram_rdata;
	ffba_pkg::entry_t    rd;

	logic             in_scan;
	logic             more;
	logic             hit_now;
	logic             miss_now;
	logic             issue;
	logic [32:0]      rd_pay;
	logic [32:0]      top_pay;
	logic [31:0]      limit_eff;
	logic [32:0]      app_need;
	logic             app_ok;
	logic             req_bad;
	logic             rsp_load;

	// payload address of a block, cut to the address space
	function automatic logic [32:0] pay_addr(input logic [31:0] start,
	                                         input logic [7:0] hdr);
		pay_addr = (33'(start) + 33'(hdr)) & PayMask;
	endfunction

	ffba_ram #(
		.WIDTH($bits(ffba_pkg::entry_t)),
		.DEPTH(MAX_BLOCKS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (issue),
		.raddr (ptr_q[IW-1:0]),
		.rdata (ram_rdata)
	);

	assign rd = ffba_pkg::entry_t'(ram_rdata);

	// shared compare unit: address match for lookups, size fit for first-fit
	always_comb begin
		in_scan  = (state_q == S_FIND) || (state_q == S_FIT);
		more     = ptr_q < ent_cnt_q;
		rd_pay   = pay_addr(rd.start, header_q);
		if (state_q == S_FIND) begin
			hit_now = rvalid_s1 && (rd_pay == {1'b0, addr_q});
		end else begin
			hit_now = rvalid_s1 && rd.free && (rd.size >= size_q);
		end
		miss_now = !rvalid_s1 && !more;
		issue    = in_scan && more && !hit_now;
	end

	always_comb begin
		top_pay   = pay_addr(heap_top_q, header_q);
		limit_eff = (heap_limit_q < LimMask) ? heap_limit_q : LimMask;
		app_need  = 33'(header_q) + 33'(size_q);
		app_ok    = (ent_cnt_q < CW'(MAX_BLOCKS)) && (heap_top_q <= limit_eff) &&
			(33'(limit_eff - heap_top_q) >= app_need);
		req_bad   = (req.payload.request_size == '0) ||
			(req.payload.request_size > ffba_pkg::MaxRequest);
		rsp_load  = (state_q == S_RESP) && (!rsp_valid_q || rsp.ready);
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_s1;
		ram_wdata = '{free: 1'b0, size: rd.size, start: rd.start};
		case (state_q)
			S_FIND: begin
				if (hit_now && !rd.free && (cmd_q == ffba_pkg::CMD_FREE)) begin
					ram_we         = 1'b1;
					ram_wdata.free = 1'b1;
				end
			end
			S_FIT: begin
				ram_we = hit_now;
			end
			S_APPEND: begin
				ram_we    = app_ok;
				ram_waddr = ent_cnt_q[IW-1:0];
				ram_wdata = '{free: 1'b0, size: size_q, start: heap_top_q};
			end
			S_FREE_OLD: begin
				ram_we    = 1'b1;
				ram_waddr = old_idx_q;
				ram_wdata = '{free: 1'b1, size: old_size_q, start: old_start_q};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	assign req.ready   = (state_q == S_IDLE);
	assign cfg.ready   = 1'b1;
	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			heap_limit_q <= ffba_pkg::HeapLimitReset;
			header_q     <= ffba_pkg::HeaderBytesReset;
			ent_cnt_q    <= '0;
			free_cnt_q   <= '0;
			free_tot_q   <= '0;
			used_tot_q   <= '0;
			heap_top_q   <= '0;
			cmd_q        <= ffba_pkg::CMD_ALLOC;
			size_q       <= '0;
			addr_q       <= '0;
			res_q        <= '0;
			status_q     <= ffba_pkg::ST_OK;
			kept_q       <= 1'b0;
			rel_q        <= 1'b0;
			old_idx_q    <= '0;
			old_size_q   <= '0;
			old_start_q  <= '0;
			ptr_q        <= '0;
			rvalid_s1    <= 1'b0;
			idx_s1       <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_q        <= '0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					ffba_pkg::REG_HEAP_LIMIT:   heap_limit_q <= cfg.data;
					ffba_pkg::REG_HEADER_BYTES: header_q     <= cfg.data[7:0];
					default: begin
						heap_limit_q <= heap_limit_q;
					end
				endcase
			end

			rvalid_s1 <= issue;
			idx_s1    <= ptr_q[IW-1:0];
			if (issue) begin
				ptr_q <= ptr_q + CW'(1);
			end

			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
				rsp_q <= '{
					result_address: res_q,
					status:         status_q,
					kept_in_place:  kept_q,
					spare_blocks:   7'(free_cnt_q),
					spare_bytes:    free_tot_q,
					used_blocks:    7'(ent_cnt_q),
					used_bytes:     used_tot_q
				};
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						cmd_q    <= req.payload.cmd;
						size_q   <= req.payload.request_size;
						addr_q   <= req.payload.block_address;
						res_q    <= '0;
						kept_q   <= 1'b0;
						rel_q    <= 1'b0;
						ptr_q    <= '0;
						status_q <= ffba_pkg::ST_IGNORED;
						state_q  <= S_RESP;
						case (req.payload.cmd)
							ffba_pkg::CMD_ALLOC: begin
								if (req_bad) begin
									status_q <= ffba_pkg::ST_BADSIZE;
								end else begin
									state_q <= S_FIT;
								end
							end
							ffba_pkg::CMD_FREE: begin
								if (req.payload.block_address != '0) begin
									state_q <= S_FIND;
								end
							end
							ffba_pkg::CMD_REALLOC: begin
								if (req_bad) begin
									status_q <= ffba_pkg::ST_BADSIZE;
								end else if (req.payload.block_address == '0) begin
									state_q <= S_FIT;
								end else begin
									state_q <= S_FIND;
								end
							end
							default: begin
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_FIND: begin
					if (hit_now) begin
						if (rd.free) begin
							status_q <= ffba_pkg::ST_IGNORED;
							state_q  <= S_RESP;
						end else if (cmd_q == ffba_pkg::CMD_FREE) begin
							free_cnt_q <= free_cnt_q + CW'(1);
							free_tot_q <= free_tot_q + 33'(rd.size);
							status_q   <= ffba_pkg::ST_OK;
							state_q    <= S_RESP;
						end else if (rd.size >= size_q) begin
							res_q    <= addr_q;
							kept_q   <= 1'b1;
							status_q <= ffba_pkg::ST_OK;
							state_q  <= S_RESP;
						end else begin
							// move: remember the old block, then run first-fit
							rel_q       <= 1'b1;
							old_idx_q   <= idx_s1;
							old_size_q  <= rd.size;
							old_start_q <= rd.start;
							ptr_q       <= '0;
							state_q     <= S_FIT;
						end
					end else if (miss_now) begin
						status_q <= ffba_pkg::ST_IGNORED;
						state_q  <= S_RESP;
					end
				end
				S_FIT: begin
					if (hit_now) begin
						free_cnt_q <= free_cnt_q - CW'(1);
						free_tot_q <= free_tot_q - 33'(rd.size);
						res_q      <= rd_pay[31:0];
						status_q   <= ffba_pkg::ST_OK;
						state_q    <= rel_q ? S_FREE_OLD : S_RESP;
					end else if (miss_now) begin
						state_q <= S_APPEND;
					end
				end
				S_APPEND: begin
					if (app_ok) begin
						ent_cnt_q  <= ent_cnt_q + CW'(1);
						used_tot_q <= used_tot_q + 33'(size_q);
						res_q      <= top_pay[31:0];
						heap_top_q <= heap_top_q + app_need[31:0];
						status_q   <= ffba_pkg::ST_OK;
						state_q    <= rel_q ? S_FREE_OLD : S_RESP;
					end else begin
						status_q <= ffba_pkg::ST_NOMEM;
						state_q  <= S_RESP;
					end
				end
				S_FREE_OLD: begin
					free_cnt_q <= free_cnt_q + CW'(1);
					free_tot_q <= free_tot_q + 33'(old_size_q);
					state_q    <= S_RESP;
				end
				S_RESP: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_free_le_count: assert property (@(posedge clk) disable iff (!arst_n)
		free_cnt_q <= ent_cnt_q)
		else $error("free block count exceeds table fill");

	a_idle_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !rvalid_s1)
		else $error("table read in flight while idle");

	a_write_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (CW'(ram_waddr) <= ent_cnt_q) && (ent_cnt_q != CW'(MAX_BLOCKS) ||
		CW'(ram_waddr) < ent_cnt_q))
		else $error("table write beyond filled entries");

	a_kept_ok: assert property (@(posedge clk) disable iff (!arst_n)
		kept_q |-> (status_q == ffba_pkg::ST_OK) && (res_q == addr_q))
		else $error("kept block without ok status");

	a_top_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_APPEND) && app_ok) |=> heap_top_q <= $past(limit_eff))
		else $error("heap top grew past limit");
`endif

endmodule

FILE: sv/ffba_ram.sv
// ----------------------------------------------------------------------------
// ffba_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ffba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: test/first_fit_block_allocator_unit_test.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator_unit_test: regression for the first-fit allocator
// Drives allocate, free and reallocate beats with random gaps on both channels.
// A scoreboard keeps its own copy of the block table, heap top and totals. It
// checks every result beat in order against the predicted one. The run starts
// with a directed burst of edge cases. Random phases follow, each with its
// own heap limit and header size.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_unit_test;

	localparam int TableDepth = 64;
	localparam int CycleLimit = 1500000;
	localparam int PhaseBeats = 305;

	class alloc_scoreboard;
		logic [31:0] blk_start [TableDepth];
		logic [26:0] blk_size [TableDepth];
		bit          blk_free [TableDepth];
		logic [6:0]  blk_count;
		logic [31:0] heap_top;
		logic [6:0]  free_count;
		logic [32:0] free_total;
		logic [32:0] used_total;
		logic [31:0] heap_limit;
		logic [7:0]  header_bytes;
		ffba_pkg::rsp_t replies_due [$];
		int          errors;

		function new();
			blk_count = '0;
			heap_top = '0;
			free_count = '0;
			free_total = '0;
			used_total = '0;
			heap_limit = ffba_pkg::HeapLimitReset;
			header_bytes = ffba_pkg::HeaderBytesReset;
			errors = 0;
		endfunction

		function void set_register(logic idx, logic [31:0] data);
			if (idx == ffba_pkg::REG_HEAP_LIMIT)
				heap_limit = data;
			else
				header_bytes = data[7:0];
		endfunction

		// payload address under the current header size, wrapped to 32 bits
		function logic [31:0] payload_addr(int i);
			return blk_start[i] + {24'd0, header_bytes};
		endfunction

		function int lookup(logic [31:0] addr);
			for (int i = 0; i < blk_count; i++)
				if (payload_addr(i) == addr)
					return i;
			return -1;
		endfunction

		// random entry that is free (or in use), -1 if there is none
		function int pick_entry(bit want_free);
			int hits [$];
			for (int i = 0; i < blk_count; i++)
				if (blk_free[i] == want_free)
					hits.push_back(i);
			if (hits.size() == 0)
				return -1;
			return hits[$urandom_range(hits.size() - 1)];
		endfunction

		function void retire_block(int i);
			blk_free[i] = 1'b1;
			free_count++;
			free_total += blk_size[i];
		endfunction

		function logic [1:0] carve(input logic [26:0] size, output logic [31:0] addr);
			longint unsigned need;
			addr = '0;
			for (int i = 0; i < blk_count; i++)
				if (blk_free[i] && blk_size[i] >= size) begin
					blk_free[i] = 1'b0;
					free_count--;
					free_total -= blk_size[i];
					addr = payload_addr(i);
					return ffba_pkg::ST_OK;
				end
			if (blk_count >= TableDepth)
				return ffba_pkg::ST_NOMEM;
			need = 64'(header_bytes) + 64'(size);
			if (heap_top > heap_limit || 64'(heap_limit - heap_top) < need)
				return ffba_pkg::ST_NOMEM;
			blk_start[blk_count] = heap_top;
			blk_size[blk_count] = size;
			blk_free[blk_count] = 1'b0;
			blk_count++;
			used_total += size;
			addr = heap_top + {24'd0, header_bytes};
			heap_top = heap_top + 32'(need);
			return ffba_pkg::ST_OK;
		endfunction

		function void note_command(ffba_pkg::req_t c);
			ffba_pkg::rsp_t y;
			int          idx;
			logic [31:0] addr;
			logic        bad;
			y = '0;
			addr = '0;
			y.status = ffba_pkg::ST_IGNORED;
			bad = (c.request_size == 0) || (c.request_size > ffba_pkg::MaxRequest);
			if (c.cmd == ffba_pkg::CMD_ALLOC) begin
				if (bad)
					y.status = ffba_pkg::ST_BADSIZE;
				else
					y.status = carve(c.request_size, addr);
			end else if (c.cmd == ffba_pkg::CMD_FREE) begin
				idx = (c.block_address != 0) ? lookup(c.block_address) : -1;
				if (idx >= 0 && !blk_free[idx]) begin
					retire_block(idx);
					y.status = ffba_pkg::ST_OK;
				end
			end else if (c.cmd == ffba_pkg::CMD_REALLOC) begin
				if (bad) begin
					y.status = ffba_pkg::ST_BADSIZE;
				end else if (c.block_address == 0) begin
					y.status = carve(c.request_size, addr);
				end else begin
					idx = lookup(c.block_address);
					if (idx >= 0 && !blk_free[idx]) begin
						if (blk_size[idx] >= c.request_size) begin
							addr = c.block_address;
							y.kept_in_place = 1'b1;
							y.status = ffba_pkg::ST_OK;
						end else begin
							// the old block goes free only once the move succeeded
							y.status = carve(c.request_size, addr);
							if (y.status == ffba_pkg::ST_OK)
								retire_block(idx);
						end
					end
				end
			end
			y.result_address = addr;
			y.spare_blocks = free_count;
			y.spare_bytes = free_total;
			y.used_blocks = blk_count;
			y.used_bytes = used_total;
			replies_due.push_back(y);
		endfunction

		task report(string what);
			errors++;
			$display("%0t mismatch: %s", $time, what);
		endtask

		task compare(string field, logic [32:0] got, logic [32:0] want);
			if (got !== want)
				report($sformatf("%s got %0h, want %0h", field, got, want));
		endtask

		task check_result(ffba_pkg::rsp_t got);
			ffba_pkg::rsp_t want;
			if (replies_due.size() == 0) begin
				report("result beat with no command outstanding");
				return;
			end
			want = replies_due.pop_front();
			compare("result_address", 33'(got.result_address), 33'(want.result_address));
			compare("status", 33'(got.status), 33'(want.status));
			compare("kept_in_place", 33'(got.kept_in_place), 33'(want.kept_in_place));
			compare("spare_blocks", 33'(got.spare_blocks), 33'(want.spare_blocks));
			compare("spare_bytes", got.spare_bytes, want.spare_bytes);
			compare("used_blocks", 33'(got.used_blocks), 33'(want.used_blocks));
			compare("used_bytes", got.used_bytes, want.used_bytes);
		endtask
	endclass

	logic clk;
	logic arst_n;
	int   idle_pct = 33;
	int   cycles;

	alloc_scoreboard sb = new();

	ffba_req_if req();
	ffba_rsp_if rsp();
	ffba_cfg_if cfg();

	first_fit_block_allocator_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic ffba_pkg::req_t beat(logic [1:0] cmd, logic [26:0] size,
	                                        logic [31:0] addr);
		ffba_pkg::req_t r;
		r.cmd = cmd;
		r.request_size = size;
		r.block_address = addr;
		return r;
	endfunction

	// mostly small requests, a few huge ones
	function automatic logic [26:0] pick_size();
		int k = $urandom_range(99);
		if (k < 70)
			return 27'($urandom_range(256, 1));
		if (k < 92)
			return 27'($urandom_range(65535, 257));
		if (k < 99)
			return 27'($urandom_range(int'(ffba_pkg::MaxRequest), 65536));
		return ffba_pkg::MaxRequest;
	endfunction

	function automatic ffba_pkg::req_t random_command();
		ffba_pkg::req_t r;
		int   k;
		int   idx;
		r = beat(ffba_pkg::CMD_ALLOC, pick_size(), $urandom);
		k = $urandom_range(99);
		if (k < 35) begin
			r.cmd = ffba_pkg::CMD_ALLOC;
		end else if (k < 60) begin
			r.cmd = ffba_pkg::CMD_FREE;
			idx = sb.pick_entry(1'b0);
			if (idx >= 0)
				r.block_address = sb.payload_addr(idx);
		end else if (k < 75) begin
			r.cmd = ffba_pkg::CMD_REALLOC;
			idx = sb.pick_entry(1'b0);
			if (idx >= 0)
				r.block_address = sb.payload_addr(idx);
			if ($urandom_range(1))
				r.request_size = 27'($urandom_range(64, 1));
		end else if (k < 80) begin
			r.cmd = ffba_pkg::CMD_REALLOC;
			r.block_address = '0;
		end else if (k < 85) begin
			// double free
			r.cmd = ffba_pkg::CMD_FREE;
			idx = sb.pick_entry(1'b1);
			if (idx >= 0)
				r.block_address = sb.payload_addr(idx);
		end else if (k < 90) begin
			r.cmd = ffba_pkg::CMD_FREE;
			idx = sb.pick_entry(1'b0);
			case ($urandom_range(2))
				0: r.block_address = '0;
				1: if (idx >= 0) r.block_address = sb.payload_addr(idx) + $urandom_range(3, 1);
				default: ;
			endcase
		end else if (k < 94) begin
			r.cmd = $urandom_range(1) ? ffba_pkg::CMD_ALLOC : ffba_pkg::CMD_REALLOC;
			r.request_size = $urandom_range(1) ? 27'd0 :
				27'($urandom_range(134217727, int'(ffba_pkg::MaxRequest) + 1));
		end else if (k < 97) begin
			r.cmd = ffba_pkg::CMD_UNUSED;
		end else begin
			r.cmd = ffba_pkg::CMD_REALLOC;
			idx = sb.pick_entry(1'b1);
			if (idx >= 0)
				r.block_address = sb.payload_addr(idx);
		end
		return r;
	endfunction

	task automatic send(input ffba_pkg::req_t r);
		if ($urandom_range(99) < idle_pct) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.payload <= r;
		do @(posedge clk); while (!req.ready);
		sb.note_command(r);
	endtask

	// drop valid and wait until every result is back
	task automatic settle();
		req.valid <= 1'b0;
		while (sb.replies_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(input logic [31:0] limit, input logic [7:0] hdr);
		cfg.valid <= 1'b1;
		cfg.index <= ffba_pkg::REG_HEAP_LIMIT;
		cfg.data <= limit;
		do @(posedge clk); while (!cfg.ready);
		cfg.index <= ffba_pkg::REG_HEADER_BYTES;
		cfg.data <= {24'd0, hdr};
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		sb.set_register(ffba_pkg::REG_HEAP_LIMIT, limit);
		sb.set_register(ffba_pkg::REG_HEADER_BYTES, {24'd0, hdr});
	endtask

	initial begin
		logic [31:0] lim;
		logic [7:0]  hdr;
		arst_n = 1'b0;
		req.valid <= 1'b0;
		req.payload <= '0;
		cfg.valid <= 1'b0;
		cfg.index <= ffba_pkg::REG_HEAP_LIMIT;
		cfg.data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed edge cases under the reset register values
		send(beat(ffba_pkg::CMD_ALLOC, 27'd0, '0));
		send(beat(ffba_pkg::CMD_ALLOC, 27'h7FF_FFFF, '0));
		send(beat(ffba_pkg::CMD_ALLOC, ffba_pkg::MaxRequest + 27'd1, '0));
		send(beat(ffba_pkg::CMD_ALLOC, ffba_pkg::MaxRequest, '0));
		send(beat(ffba_pkg::CMD_ALLOC, 27'd1, '0));
		send(beat(ffba_pkg::CMD_FREE, 27'd5, '0));
		send(beat(ffba_pkg::CMD_FREE, 27'd5, 32'hFFFF_FFFF));
		send(beat(ffba_pkg::CMD_FREE, 27'd0, sb.payload_addr(1)));
		send(beat(ffba_pkg::CMD_FREE, 27'd0, sb.payload_addr(1)));
		send(beat(ffba_pkg::CMD_REALLOC, 27'd50, '0));
		send(beat(ffba_pkg::CMD_ALLOC, 27'd1, '0));
		send(beat(ffba_pkg::CMD_REALLOC, 27'd10, sb.payload_addr(0)));
		send(beat(ffba_pkg::CMD_REALLOC, 27'd500, sb.payload_addr(2)));
		send(beat(ffba_pkg::CMD_REALLOC, 27'd20, sb.payload_addr(2)));
		send(beat(ffba_pkg::CMD_REALLOC, 27'd0, sb.payload_addr(0)));
		send(beat(ffba_pkg::CMD_REALLOC, 27'd20, sb.payload_addr(0) + 32'd1));
		send(beat(ffba_pkg::CMD_UNUSED, 27'h7FF_FFFF, 32'hFFFF_FFFF));
		send(beat(ffba_pkg::CMD_FREE, 27'd0, sb.payload_addr(0)));
		send(beat(ffba_pkg::CMD_ALLOC, ffba_pkg::MaxRequest - 27'd1, '0));
		send(beat(ffba_pkg::CMD_ALLOC, 27'd40, '0));
		settle();

		// heap limit right at the boundary of one more small block
		configure(sb.heap_top + 32'd101, 8'd1);
		send(beat(ffba_pkg::CMD_ALLOC, 27'd101, '0));
		send(beat(ffba_pkg::CMD_REALLOC, 27'd1000, sb.payload_addr(3)));
		send(beat(ffba_pkg::CMD_ALLOC, 27'd100, '0));
		send(beat(ffba_pkg::CMD_ALLOC, 27'd1, '0));
		settle();
		configure(32'd0, 8'd255);
		send(beat(ffba_pkg::CMD_ALLOC, 27'd1, '0));
		send(beat(ffba_pkg::CMD_FREE, 27'd0, sb.payload_addr(3)));
		settle();

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: begin lim = sb.heap_top + 32'd200000; hdr = 8'd1; end
				1: begin lim = 32'd0; hdr = 8'd255; end
				2: begin lim = $urandom; hdr = 8'($urandom_range(255, 1)); end
				3: begin
					lim = ffba_pkg::HeapLimitReset;
					hdr = ffba_pkg::HeaderBytesReset;
				end
				4: begin
					lim = sb.heap_top + $urandom_range(1 << 24);
					hdr = 8'($urandom_range(255, 1));
				end
				default: begin lim = 32'hFFFF_FFFF; hdr = 8'd255; end
			endcase
			configure(lim, hdr);
			// one phase runs without any gaps on either side
			idle_pct = (p == 3) ? 0 : 33;
			repeat (PhaseBeats) send(random_command());
			settle();
		end

		repeat (150) @(posedge clk);
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// result side: random back-pressure plus two long hold-offs
	initial begin
		int seen;
		int hold_left;
		seen = 0;
		hold_left = 0;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready) begin
				sb.check_result(rsp.payload);
				seen++;
				if (seen == 250 || seen == 1300)
					hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= arst_n && ($urandom_range(99) >= idle_pct);
			end
		end
	end

	initial begin
		cycles = 0;
		while (cycles < CycleLimit) begin
			@(posedge clk);
			cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: sim.f
sv/ffba_pkg.sv
sv/ffba_ifs.sv
sv/ffba_ram.sv
sv/first_fit_block_allocator_unit.sv
test/first_fit_block_allocator_unit_test.sv
